### src/pif_pkg.sv
// shared types, constants and helpers for the printf integer field formatter
package pif_pkg;

    localparam int MAX_FIELD_DEF = 48;
    localparam int CNT_W         = 7;
    localparam int NUM_DIG       = 24;
    localparam int IDX_W         = 5;
    localparam int ND_W          = 5;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_OCT  = 3'd4;
    localparam logic [2:0] OP_CHAR = 3'd5;
    localparam logic [2:0] OP_PCT  = 3'd6;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_X_LOW   = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;

    localparam logic [0:15][7:0] HEX_UPPER = "0123456789ABCDEF";
    localparam logic [0:15][7:0] HEX_LOWER = "0123456789abcdef";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIZE,
        ST_PLAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic size;
        logic plan;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic is_dec;
        logic is_direct;
        logic conv_done;
        logic scan_done;
        logic out_free;
        logic emit_last;
    } t_stat;

    function automatic logic [7:0] f_digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        c = upper ? HEX_UPPER[d] : HEX_LOWER[d];
        return c;
    endfunction

endpackage

### src/pif_ctrl.sv
// controller state machine sequencing load, conversion, digit scan, layout and output
module pif_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pif_pkg::t_stat i_stat,
    output pif_pkg::t_cmd  o_cmd
);
    import pif_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (!i_stat.is_dec || i_stat.conv_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.is_direct || i_stat.scan_done) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_state = ST_PLAN;
            end
            ST_PLAN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV: begin
                o_cmd.conv_step = i_stat.is_dec;
            end
            ST_SCAN: begin
                o_cmd.scan_step = !i_stat.is_direct;
            end
            ST_SIZE: begin
                o_cmd.size = 1'b1;
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit_step = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### src/pif_datapath.sv
// datapath: operand prep, serial binary to bcd, digit scan, field layout, output register
module pif_datapath #(
    parameter int MAX_FIELD = pif_pkg::MAX_FIELD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pif_pkg::t_cmd        i_cmd,
    output pif_pkg::t_stat       o_stat,
    input  logic [2:0]           i_operation,
    input  logic [63:0]          i_value,
    input  logic [1:0]           i_size_code,
    input  logic                 i_flag_plus,
    input  logic                 i_flag_space,
    input  logic                 i_flag_left,
    input  logic                 i_flag_zero,
    input  logic                 i_flag_alt,
    input  logic [5:0]           i_field_width,
    input  logic signed [6:0]    i_precision,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_char_code,
    output logic                 o_is_last,
    output logic                 o_no_char
);
    import pif_pkg::*;

    // operand registers
    logic                r_dec;
    logic                r_direct;
    logic                r_bad;
    logic                r_upper;
    logic [7:0]          r_lit;
    logic [7:0]          r_pre0;
    logic [7:0]          r_pre1;
    logic [1:0]          r_np;
    logic [5:0]          r_prec;
    logic                r_prec_zero;
    logic                r_zp;
    logic                r_left;
    logic [5:0]          r_width;
    logic [63:0]         r_bin;
    logic [CNT_W-1:0]    r_cnt;
    logic [3:0]          r_dig [NUM_DIG];
    logic [IDX_W-1:0]    r_idx;
    logic [ND_W-1:0]     r_nd;

    // layout registers
    logic [CNT_W-1:0]    r_nz;
    logic [CNT_W-1:0]    r_tot;
    logic [CNT_W-1:0]    r_pad;
    logic [CNT_W-1:0]    r_b1;
    logic [CNT_W-1:0]    r_b2;
    logic [CNT_W-1:0]    r_b3;
    logic [CNT_W-1:0]    r_b4;
    logic [CNT_W-1:0]    r_last;
    logic                r_empty;
    logic [CNT_W-1:0]    r_k;

    // output register
    logic                r_out_valid;
    logic [7:0]          r_char;
    logic                r_is_last;
    logic                r_no_char;

    // load-time operand prep
    logic [63:0]         masked;
    logic [63:0]         mask;
    logic                sbit;
    logic                neg;
    logic [63:0]         mag;
    logic [63:0]         aligned;
    logic [CNT_W-1:0]    nbits;
    logic                nonzero;
    logic                prec_given;
    logic [5:0]          prec_sat;
    logic [5:0]          width_sat;
    logic [7:0]          pre0;
    logic [7:0]          pre1;
    logic [1:0]          np;
    logic [3:0]          ld_dig [NUM_DIG];
    logic [65:0]         mag_ext;

    always_comb begin
        unique case (i_size_code)
            SZ_8:    begin mask = 64'h0000_0000_0000_00ff; sbit = i_value[7];  end
            SZ_16:   begin mask = 64'h0000_0000_0000_ffff; sbit = i_value[15]; end
            SZ_32:   begin mask = 64'h0000_0000_ffff_ffff; sbit = i_value[31]; end
            default: begin mask = 64'hffff_ffff_ffff_ffff; sbit = i_value[63]; end
        endcase
        masked  = i_value & mask;
        nonzero = |masked;
        neg     = (i_operation == OP_SDEC) && sbit;
        mag     = neg ? ((~masked + 64'd1) & mask) : masked;
        unique case (i_size_code)
            SZ_8:    begin aligned = {mag[7:0], 56'd0};  nbits = CNT_W'(8);  end
            SZ_16:   begin aligned = {mag[15:0], 48'd0}; nbits = CNT_W'(16); end
            SZ_32:   begin aligned = {mag[31:0], 32'd0}; nbits = CNT_W'(32); end
            default: begin aligned = mag;                nbits = CNT_W'(64); end
        endcase

        prec_given = !i_precision[6];
        prec_sat   = (i_precision[5:0] > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_precision[5:0];
        width_sat  = (i_field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : i_field_width;

        pre0 = CH_ZERO;
        pre1 = CH_X_LOW;
        np   = 2'd0;
        case (i_operation) inside
            OP_SDEC: begin
                if (neg) begin
                    pre0 = CH_MINUS;
                    np   = 2'd1;
                end else if (i_flag_plus) begin
                    pre0 = CH_PLUS;
                    np   = 2'd1;
                end else if (i_flag_space) begin
                    pre0 = CH_SPACE;
                    np   = 2'd1;
                end
            end
            OP_HEXL, OP_HEXU: begin
                pre1 = (i_operation == OP_HEXU) ? CH_X_UP : CH_X_LOW;
                if (i_flag_alt && nonzero) begin
                    np = 2'd2;
                end
            end
            OP_OCT: begin
                if (i_flag_alt && nonzero) begin
                    np = 2'd1;
                end
            end
            default: begin
                np = 2'd0;
            end
        endcase

        mag_ext = {2'b00, mag};
        for (int i = 0; i < NUM_DIG; i++) begin
            ld_dig[i] = 4'd0;
        end
        if (i_operation == OP_HEXL || i_operation == OP_HEXU) begin
            for (int i = 0; i < 16; i++) begin
                ld_dig[i] = mag[4*i +: 4];
            end
        end else if (i_operation == OP_OCT) begin
            for (int i = 0; i < 22; i++) begin
                ld_dig[i] = {1'b0, mag_ext[3*i +: 3]};
            end
        end
    end

    // shift-add-3 step
    logic [3:0]          adj [NUM_DIG];
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? (r_dig[i] + 4'd3) : r_dig[i];
        end
    end

    // scan and layout
    logic [3:0]          cur_dig;
    logic                cur_nz;
    logic [CNT_W-1:0]    prec_w;
    logic [CNT_W-1:0]    nd_w;
    logic [CNT_W-1:0]    np_w;
    logic [CNT_W-1:0]    nz;
    logic [CNT_W-1:0]    tot;
    logic [CNT_W-1:0]    pad;
    logic [CNT_W-1:0]    width_w;
    logic [CNT_W-1:0]    grand;
    logic [CNT_W-1:0]    lead;
    logic [CNT_W-1:0]    zeros;

    assign cur_dig = r_dig[r_idx];
    assign cur_nz  = (cur_dig != 4'd0);
    assign prec_w  = CNT_W'(r_prec);
    assign nd_w    = CNT_W'(r_nd);
    assign np_w    = CNT_W'(r_np);
    assign width_w = CNT_W'(r_width);
    assign nz      = (prec_w > nd_w) ? (prec_w - nd_w) : '0;
    assign tot     = np_w + nz + nd_w;
    assign pad     = (width_w > tot) ? (width_w - tot) : '0;
    assign grand   = r_tot + r_pad;
    assign lead    = (!r_left && !r_zp) ? r_pad : '0;
    assign zeros   = r_nz + (r_zp ? r_pad : '0);

    // character at the current position
    logic [7:0]          cur_char;
    logic                in_digits;
    always_comb begin
        in_digits = 1'b0;
        if (r_empty) begin
            cur_char = 8'd0;
        end else if (r_k < r_b1) begin
            cur_char = CH_SPACE;
        end else if (r_k < r_b2) begin
            cur_char = (r_k == r_b1) ? r_pre0 : r_pre1;
        end else if (r_k < r_b3) begin
            cur_char = CH_ZERO;
        end else if (r_k < r_b4) begin
            in_digits = 1'b1;
            cur_char  = r_direct ? r_lit : f_digit_char(cur_dig, r_upper);
        end else begin
            cur_char = CH_SPACE;
        end
    end

    always_comb begin
        o_stat.is_dec    = r_dec;
        o_stat.is_direct = r_direct;
        o_stat.conv_done = (r_cnt == CNT_W'(1));
        o_stat.scan_done = cur_nz || (r_idx == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.emit_last = (r_k == r_last);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dec       <= (i_operation == OP_SDEC) || (i_operation == OP_UDEC);
            r_direct    <= (i_operation == OP_CHAR) || (i_operation == OP_PCT) ||
                           (i_operation > OP_PCT);
            r_bad       <= (i_operation > OP_PCT);
            r_upper     <= (i_operation == OP_HEXU);
            r_lit       <= (i_operation == OP_CHAR) ? i_value[7:0] : CH_PERCENT;
            r_pre0      <= pre0;
            r_pre1      <= pre1;
            r_np        <= np;
            r_left      <= i_flag_left;
            r_width     <= width_sat;
            r_bin       <= aligned;
            r_cnt       <= nbits;
            r_dig       <= ld_dig;
            r_idx       <= IDX_W'(NUM_DIG - 1);
            if (i_operation == OP_CHAR || i_operation == OP_PCT) begin
                r_prec      <= '0;
                r_prec_zero <= 1'b0;
                r_zp        <= 1'b0;
                r_nd        <= ND_W'(1);
            end else begin
                r_prec      <= prec_given ? prec_sat : '0;
                r_prec_zero <= prec_given && (i_precision[5:0] == 6'd0);
                r_zp        <= i_flag_zero && !prec_given && !i_flag_left;
                r_nd        <= '0;
            end
        end
        if (i_cmd.conv_step) begin
            r_dig[0] <= {adj[0][2:0], r_bin[63]};
            for (int i = 1; i < NUM_DIG; i++) begin
                r_dig[i] <= {adj[i][2:0], adj[i-1][3]};
            end
            r_bin <= {r_bin[62:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.scan_step) begin
            if (cur_nz) begin
                r_nd <= ND_W'(r_idx) + ND_W'(1);
            end else if (r_idx == '0) begin
                r_nd <= r_prec_zero ? '0 : ND_W'(1);
            end else begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
        if (i_cmd.size) begin
            r_nz  <= nz;
            r_tot <= tot;
            r_pad <= pad;
        end
        if (i_cmd.plan) begin
            r_b1    <= lead;
            r_b2    <= lead + np_w;
            r_b3    <= lead + np_w + zeros;
            r_b4    <= lead + np_w + zeros + nd_w;
            r_empty <= r_bad || (grand == '0);
            r_last  <= (r_bad || (grand == '0)) ? '0 : (grand - CNT_W'(1));
            r_k     <= '0;
        end
        if (i_cmd.emit_step) begin
            r_k       <= r_k + CNT_W'(1);
            r_char    <= cur_char;
            r_is_last <= (r_k == r_last);
            r_no_char <= r_empty;
            if (in_digits && r_idx != '0) begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_is_last;
    assign o_no_char   = r_no_char;

endmodule

### src/printf_integer_field_formatter.sv
// top level of the printf integer field formatter: controller plus datapath
// steps in order are load, serial binary to bcd conversion (decimal only), a scan for the
// leading digit (skipped for char and percent), layout in the size and plan states, then one
// character per cycle while the receiver keeps up; the next directive is accepted while the
// last character still waits; synchronous active-low reset idles the fsm
module printf_integer_field_formatter #(
    parameter int MAX_FIELD = pif_pkg::MAX_FIELD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_operation,
    input  logic [63:0]       i_value,
    input  logic [1:0]        i_size_code,
    input  logic              i_flag_plus,
    input  logic              i_flag_space,
    input  logic              i_flag_left,
    input  logic              i_flag_zero,
    input  logic              i_flag_alt,
    input  logic [5:0]        i_field_width,
    input  logic signed [6:0] i_precision,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_char_code,
    output logic              o_is_last,
    output logic              o_no_char
);
    import pif_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pif_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_size_code   (i_size_code),
        .i_flag_plus   (i_flag_plus),
        .i_flag_space  (i_flag_space),
        .i_flag_left   (i_flag_left),
        .i_flag_zero   (i_flag_zero),
        .i_flag_alt    (i_flag_alt),
        .i_field_width (i_field_width),
        .i_precision   (i_precision),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_code   (o_char_code),
        .o_is_last     (o_is_last),
        .o_no_char     (o_no_char)
    );

endmodule

### bench/printf_integer_field_formatter_checker.sv
// checker for the printf integer field formatter: watches both channels, predicts and compares
`timescale 1ns / 100ps
module printf_integer_field_formatter_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [2:0]        i_operation,
    input  logic [63:0]       i_value,
    input  logic [1:0]        i_size_code,
    input  logic              i_flag_plus,
    input  logic              i_flag_space,
    input  logic              i_flag_left,
    input  logic              i_flag_zero,
    input  logic              i_flag_alt,
    input  logic [5:0]        i_field_width,
    input  logic signed [6:0] i_precision,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_is_last,
    input  logic              i_no_char,
    output int                o_errors,
    output int                o_pending
);
    import pif_pkg::*;

    localparam int         FIELD_MAX = MAX_FIELD_DEF;
    localparam logic [7:0] CH_A_UP   = "A";
    localparam logic [7:0] CH_A_LOW  = "a";

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       none;
    } t_field_char;

    t_field_char expected_chars[$];
    int          mismatches = 0;
    int          pending = 0;

    assign o_errors  = mismatches;
    assign o_pending = pending;

    function automatic void format_directive(
        input logic [2:0]        op,
        input logic [63:0]       value,
        input logic [1:0]        sz,
        input logic              plus,
        input logic              space,
        input logic              left,
        input logic              zero,
        input logic              alt,
        input logic [5:0]        fw,
        input logic signed [6:0] md
    );
        int          width;
        int          prec;
        int          bits;
        int          nz;
        int          pad;
        int          i;
        logic [63:0] mag;
        logic [63:0] mask;
        logic [63:0] base;
        logic [63:0] rem;
        logic        upper;
        logic        zero_ok;
        logic [7:0]  prefix[$];
        logic [7:0]  digits[$];
        logic [7:0]  field[$];
        t_field_char fc;

        width   = fw;
        prec    = md;
        nz      = 0;
        upper   = 1'b0;
        zero_ok = 1'b0;
        base    = 64'd10;
        if (prec < 0)
            prec = -1;
        if (prec > FIELD_MAX)
            prec = FIELD_MAX;
        if (width > FIELD_MAX)
            width = FIELD_MAX;

        case (op) inside
            OP_CHAR, OP_PCT: begin
                digits.push_back(op == OP_CHAR ? value[7:0] : CH_PERCENT);
            end
            OP_SDEC, OP_UDEC, OP_HEXL, OP_HEXU, OP_OCT: begin
                bits = 8 << sz;
                mask = (sz == SZ_64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
                mag  = value & mask;
                if (op == OP_SDEC) begin
                    if ((mag & (64'd1 << (bits - 1))) != 64'd0) begin
                        mag = (~mag + 64'd1) & mask;
                        prefix.push_back(CH_MINUS);
                    end else if (plus) begin
                        prefix.push_back(CH_PLUS);
                    end else if (space) begin
                        prefix.push_back(CH_SPACE);
                    end
                end else if (op == OP_HEXL || op == OP_HEXU) begin
                    base  = 64'd16;
                    upper = (op == OP_HEXU);
                    if (alt && mag != 64'd0) begin
                        prefix.push_back(CH_ZERO);
                        prefix.push_back(upper ? CH_X_UP : CH_X_LOW);
                    end
                end else if (op == OP_OCT) begin
                    base = 64'd8;
                    if (alt && mag != 64'd0)
                        prefix.push_back(CH_ZERO);
                end
                if (!(mag == 64'd0 && prec == 0)) begin
                    if (mag == 64'd0)
                        digits.push_back(CH_ZERO);
                    while (mag != 64'd0) begin
                        rem = mag % base;
                        if (rem < 64'd10)
                            digits.push_front(CH_ZERO + rem[7:0]);
                        else
                            digits.push_front((upper ? CH_A_UP : CH_A_LOW) + rem[7:0] - 8'd10);
                        mag = mag / base;
                    end
                end
                if (prec > digits.size())
                    nz = prec - digits.size();
                zero_ok = (prec < 0);
            end
            default: begin
                width = 0;
            end
        endcase

        pad = width - (prefix.size() + nz + digits.size());
        if (pad < 0)
            pad = 0;

        if (left) begin
            field = prefix;
            for (i = 0; i < nz; i++) field.push_back(CH_ZERO);
            field = {field, digits};
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
        end else if (zero && zero_ok) begin
            field = prefix;
            for (i = 0; i < pad + nz; i++) field.push_back(CH_ZERO);
            field = {field, digits};
        end else begin
            for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
            field = {field, prefix};
            for (i = 0; i < nz; i++) field.push_back(CH_ZERO);
            field = {field, digits};
        end

        if (field.size() == 0) begin
            fc.code = 8'h00;
            fc.last = 1'b1;
            fc.none = 1'b1;
            expected_chars.push_back(fc);
        end else begin
            for (i = 0; i < field.size(); i++) begin
                fc.code = field[i];
                fc.last = (i == field.size() - 1);
                fc.none = 1'b0;
                expected_chars.push_back(fc);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_field_char got;
        t_field_char want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                format_directive(i_operation, i_value, i_size_code, i_flag_plus, i_flag_space,
                                 i_flag_left, i_flag_zero, i_flag_alt, i_field_width,
                                 i_precision);
            if (i_out_valid && i_out_ready) begin
                got.code = i_char_code;
                got.last = i_is_last;
                got.none = i_no_char;
                if (expected_chars.size() == 0) begin
                    $display("%0t: extra char transfer, expected none, got %h last %b empty %b",
                             $time, got.code, got.last, got.none);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    if (got.last != want.last || got.none != want.none ||
                        (!want.none && got.code != want.code)) begin
                        $display("%0t: mismatch, want %h last %b none %b, got %h last %b none %b",
                                 $time, want.code, want.last, want.none,
                                 got.code, got.last, got.none);
                        mismatches++;
                    end
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

### bench/printf_integer_field_formatter_test.sv
// top of the printf integer field formatter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module printf_integer_field_formatter_test;
    import pif_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int         HOLD_LEN  = 400;

    // flag bits: plus, space, left, zero, alt from bit 0 up
    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_PLUS  = 5'b00001;
    localparam logic [4:0] F_SPACE = 5'b00010;
    localparam logic [4:0] F_LEFT  = 5'b00100;
    localparam logic [4:0] F_ZERO  = 5'b01000;
    localparam logic [4:0] F_ALT   = 5'b10000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [2:0]        operation   = '0;
    logic [63:0]       value       = '0;
    logic [1:0]        size_code   = '0;
    logic              flag_plus   = 1'b0;
    logic              flag_space  = 1'b0;
    logic              flag_left   = 1'b0;
    logic              flag_zero   = 1'b0;
    logic              flag_alt    = 1'b0;
    logic [5:0]        field_width = '0;
    logic signed [6:0] precision   = -7'sd1;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [7:0]        char_code;
    logic              is_last;
    logic              no_char;

    int   tx_idle_pct = 7;
    int   rx_idle_pct = 53;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;
    int   hold_left   = 0;
    int   errors;
    int   pending;

    always #4 clk = ~clk;

    printf_integer_field_formatter dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (operation),
        .i_value       (value),
        .i_size_code   (size_code),
        .i_flag_plus   (flag_plus),
        .i_flag_space  (flag_space),
        .i_flag_left   (flag_left),
        .i_flag_zero   (flag_zero),
        .i_flag_alt    (flag_alt),
        .i_field_width (field_width),
        .i_precision   (precision),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_char_code   (char_code),
        .o_is_last     (is_last),
        .o_no_char     (no_char)
    );

    printf_integer_field_formatter_checker field_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (operation),
        .i_value       (value),
        .i_size_code   (size_code),
        .i_flag_plus   (flag_plus),
        .i_flag_space  (flag_space),
        .i_flag_left   (flag_left),
        .i_flag_zero   (flag_zero),
        .i_flag_alt    (flag_alt),
        .i_field_width (field_width),
        .i_precision   (precision),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_char_code   (char_code),
        .i_is_last     (is_last),
        .i_no_char     (no_char),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // receiver side, with one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_LEN;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_directive(
        input logic [2:0]        op,
        input logic [63:0]       val,
        input logic [1:0]        sz,
        input logic [4:0]        fl,
        input logic [5:0]        fw,
        input logic signed [6:0] md
    );
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
        end
        operation   <= op;
        value       <= val;
        size_code   <= sz;
        flag_plus   <= fl[0];
        flag_space  <= fl[1];
        flag_left   <= fl[2];
        flag_zero   <= fl[3];
        flag_alt    <= fl[4];
        field_width <= fw;
        precision   <= md;
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_directive();
        logic [2:0]        op;
        logic [1:0]        sz;
        logic [63:0]       val;
        logic [5:0]        fw;
        logic signed [6:0] md;
        logic [4:0]        flags;
        op    = ($urandom_range(15) == 0) ? OP_UNUSED : 3'($urandom_range(6));
        sz    = 2'($urandom_range(3));
        flags = 5'($urandom_range(31));
        case ($urandom_range(5))
            0: val = 64'd0;
            1: val = 64'($urandom_range(255));
            2: val = {$urandom, $urandom};
            3: val = {64{1'b1}};
            4: val = (64'd1 << ((8 << sz) - 1)) - 64'($urandom_range(1));
            default: val = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        fw = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
        case ($urandom_range(9))
            5, 6, 7: md = 7'($urandom_range(10));
            8:       md = 7'($urandom_range(127));
            9:       md = 7'($urandom_range(63, 48));
            default: md = -7'sd1;
        endcase
        send_directive(op, val, sz, flags, fw, md);
    endtask

    initial begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_directive(OP_SDEC, 64'd0, SZ_32, F_NONE, 6'd0, -7'sd1);
        send_directive(OP_SDEC, 64'd0, SZ_32, F_NONE, 6'd0, 7'sd0);
        send_directive(OP_SDEC, 64'h80, SZ_8, F_NONE, 6'd0, -7'sd1);
        send_directive(OP_SDEC, 64'h8000_0000_0000_0000, SZ_64, F_PLUS, 6'd0, -7'sd1);
        send_directive(OP_UDEC, {64{1'b1}}, SZ_64, F_PLUS | F_SPACE, 6'd48, -7'sd1);
        send_directive(OP_HEXL, 64'hdead_beef, SZ_32, F_ALT, 6'd0, -7'sd1);
        send_directive(OP_HEXU, 64'hab_cdef, SZ_64, F_ZERO | F_ALT, 6'd20, -7'sd1);
        send_directive(OP_OCT, 64'hff, SZ_8, F_ALT, 6'd0, -7'sd1);
        send_directive(OP_OCT, 64'd0, SZ_16, F_ALT, 6'd3, -7'sd1);
        send_directive(OP_CHAR, 64'h41, SZ_8, F_PLUS | F_SPACE | F_LEFT | F_ALT, 6'd5, 7'sd3);
        send_directive(OP_CHAR, 64'hffff_ff7e, SZ_64, F_ZERO, 6'd5, 7'sd0);
        send_directive(OP_PCT, {64{1'b1}}, SZ_16, F_PLUS | F_ZERO | F_ALT, 6'd3, -7'sd1);
        send_directive(OP_UNUSED, 64'd77, SZ_32, F_PLUS | F_SPACE, 6'd9, 7'sd4);
        send_directive(OP_SDEC, 64'd42, SZ_32, F_SPACE | F_ZERO, 6'd10, -7'sd1);
        send_directive(OP_SDEC, 64'd42, SZ_32, F_PLUS | F_ZERO, 6'd10, 7'sd5);
        send_directive(OP_SDEC, 64'hfb, SZ_8, F_LEFT | F_ZERO, 6'd8, -7'sd1);
        send_directive(OP_HEXL, 64'd1, SZ_64, F_ALT, 6'd63, 7'sd63);
        send_directive(OP_UDEC, 64'd123, SZ_16, F_ZERO, 6'd12, -7'sd2);
        send_directive(OP_SDEC, 64'h8000_0000, SZ_32, F_ZERO, 6'd14, -7'sd64);
        send_directive(OP_UDEC, 64'h1234_5678, SZ_16, F_NONE, 6'd0, -7'sd1);
        send_directive(OP_HEXL, 64'd0, SZ_8, F_PLUS | F_SPACE | F_ALT, 6'd0, -7'sd1);
        send_directive(OP_OCT, 64'd0, SZ_32, F_ALT, 6'd5, 7'sd0);
        send_directive(OP_SDEC, 64'd0, SZ_64, F_PLUS, 6'd0, 7'sd0);
        send_directive(OP_OCT, {64{1'b1}}, SZ_64, F_ALT, 6'd0, -7'sd1);
        send_directive(OP_SDEC, 64'hffff, SZ_16, F_ZERO, 6'd6, -7'sd1);

        for (i = 0; i < 32; i++) send_random_directive();

        tx_idle_pct = 53;
        rx_idle_pct <= 7;
        for (i = 0; i < 32; i++) send_random_directive();

        // no idling, with one long receiver hold-off so the block backs up
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
        for (i = 0; i < 32; i++) send_random_directive();
        in_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
